[design/tcpop_pkg.sv]
`timescale 1ns / 1ps
package tcpop_pkg;

   // parse phases
   localparam logic [2:0] PH_KIND = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_BODY = 3'd2;
   localparam logic [2:0] PH_DONE = 3'd3;
   localparam logic [2:0] PH_ERR  = 3'd4;

   // option kinds
   localparam logic [7:0] OPT_EOL   = 8'd0;
   localparam logic [7:0] OPT_NOP   = 8'd1;
   localparam logic [7:0] OPT_MSS   = 8'd2;
   localparam logic [7:0] OPT_WS    = 8'd3;
   localparam logic [7:0] OPT_SACKP = 8'd4;

   // option lengths
   localparam logic [7:0] LEN_MSS     = 8'd4;
   localparam logic [7:0] LEN_WS      = 8'd3;
   localparam logic [7:0] LEN_SACKP   = 8'd2;
   localparam logic [7:0] MIN_OPT_LEN = 8'd2;

   localparam logic [3:0]  SHIFT_ABSENT  = 4'hf;
   localparam logic [3:0]  SHIFT_MAX     = 4'd14;
   localparam logic [15:0] MIN_MSS_RESET = 16'd536;

   // input beat kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] opt_byte;
   } beat_type;

   typedef struct packed {
      logic [15:0] mss;
      logic [3:0]  window_shift;
      logic        sack_permitted;
      logic        malformed;
   } summary_type;

endpackage

[design/tcpop_if.sv]
`timescale 1ns / 1ps
interface tcpop_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] opt_byte;
   modport source (output valid, output kind, output opt_byte, input ready);
   modport sink (input valid, input kind, input opt_byte, output ready);
endinterface

interface tcpop_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] mss;
   logic [3:0]  window_shift;
   logic        sack_permitted;
   logic        malformed;
   modport source (output valid, output mss, output window_shift,
                   output sack_permitted, output malformed, input ready);
   modport sink (input valid, input mss, input window_shift,
                 input sack_permitted, input malformed, output ready);
endinterface

interface tcpop_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] min_mss;
   modport source (output valid, output min_mss, input ready);
   modport sink (input valid, input min_mss, output ready);
endinterface

[design/tcpop_in_reg.sv]
`timescale 1ns / 1ps
module tcpop_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                consume,
   input  tcpop_pkg::beat_type beat_in,
   output logic                beat_valid,
   output tcpop_pkg::beat_type beat_out
);

   logic                valid_ff, valid_in;
   tcpop_pkg::beat_type beat_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat_in;
      end
   end

   assign beat_valid = valid_ff;
   assign beat_out   = beat_ff;

endmodule

[design/tcpop_parse.sv]
`timescale 1ns / 1ps
module tcpop_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  tcpop_pkg::beat_type    beat,
   input  logic [15:0]            min_mss,
   output tcpop_pkg::summary_type result
);

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  size_ff, size_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] mss_ff, mss_in;
   logic [3:0]  shift_ff, shift_in;
   logic        sack_ff, sack_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  b;
   logic [15:0] mss_full;
   logic [7:0]  left_dec;

   assign b        = beat.opt_byte;
   assign mss_full = {held_ff, b};
   assign left_dec = left_ff - 8'd1;

   always_comb begin
      phase_in = phase_ff;
      code_in  = code_ff;
      size_in  = size_ff;
      left_in  = left_ff;
      mss_in   = mss_ff;
      shift_in = shift_ff;
      sack_in  = sack_ff;
      held_in  = held_ff;
      if (take) begin
         if (beat.kind == tcpop_pkg::KIND_END) begin
            phase_in = tcpop_pkg::PH_KIND;
            code_in  = 8'd0;
            size_in  = 8'd0;
            left_in  = 8'd0;
            mss_in   = 16'd0;
            shift_in = tcpop_pkg::SHIFT_ABSENT;
            sack_in  = 1'b0;
            held_in  = 8'd0;
         end else begin
            unique case (phase_ff)
               tcpop_pkg::PH_KIND: begin
                  if (b == tcpop_pkg::OPT_EOL) begin
                     phase_in = tcpop_pkg::PH_DONE;
                  end else if (b != tcpop_pkg::OPT_NOP) begin
                     code_in  = b;
                     phase_in = tcpop_pkg::PH_LEN;
                  end
               end
               tcpop_pkg::PH_LEN: begin
                  size_in = b;
                  if (b < tcpop_pkg::MIN_OPT_LEN) begin
                     phase_in = tcpop_pkg::PH_ERR;
                  end else if (b == tcpop_pkg::MIN_OPT_LEN) begin
                     if (code_ff == tcpop_pkg::OPT_SACKP) begin
                        sack_in = 1'b1;
                     end
                     phase_in = tcpop_pkg::PH_KIND;
                  end else begin
                     left_in  = b - tcpop_pkg::MIN_OPT_LEN;
                     phase_in = tcpop_pkg::PH_BODY;
                  end
               end
               tcpop_pkg::PH_BODY: begin
                  left_in = left_dec;
                  if (left_dec == 8'd0) begin
                     phase_in = tcpop_pkg::PH_KIND;
                  end
                  if (code_ff == tcpop_pkg::OPT_MSS && size_ff == tcpop_pkg::LEN_MSS) begin
                     if (left_ff == 8'd2) begin
                        held_in = b;
                     end else begin
                        mss_in = mss_full;
                        // small mss aborts the area but keeps the value
                        if (mss_full < min_mss) begin
                           phase_in = tcpop_pkg::PH_ERR;
                           left_in  = 8'd0;
                        end
                     end
                  end else if (code_ff == tcpop_pkg::OPT_WS &&
                               size_ff == tcpop_pkg::LEN_WS) begin
                     shift_in = (b > {4'd0, tcpop_pkg::SHIFT_MAX}) ?
                                tcpop_pkg::SHIFT_MAX : b[3:0];
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tcpop_pkg::PH_KIND;
         code_ff  <= 8'd0;
         size_ff  <= 8'd0;
         left_ff  <= 8'd0;
         mss_ff   <= 16'd0;
         shift_ff <= tcpop_pkg::SHIFT_ABSENT;
         sack_ff  <= 1'b0;
         held_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         code_ff  <= code_in;
         size_ff  <= size_in;
         left_ff  <= left_in;
         mss_ff   <= mss_in;
         shift_ff <= shift_in;
         sack_ff  <= sack_in;
         held_ff  <= held_in;
      end
   end

   assign result.mss            = mss_ff;
   assign result.window_shift   = shift_ff;
   assign result.sack_permitted = sack_ff;
   assign result.malformed      = (phase_ff == tcpop_pkg::PH_ERR) ||
                                  (phase_ff == tcpop_pkg::PH_LEN) ||
                                  (phase_ff == tcpop_pkg::PH_BODY);

`ifndef SYNTH
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (take && beat.kind == tcpop_pkg::KIND_END) |=>
      (phase_ff == tcpop_pkg::PH_KIND && mss_ff == 16'd0 && !sack_ff &&
       shift_ff == tcpop_pkg::SHIFT_ABSENT))
      else $error("parser state not cleared after end beat");
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (take && beat.kind == tcpop_pkg::KIND_BYTE && phase_ff == tcpop_pkg::PH_ERR) |=>
      (phase_ff == tcpop_pkg::PH_ERR))
      else $error("error phase left before end beat");
   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tcpop_pkg::PH_BODY) |-> (left_ff != 8'd0))
      else $error("option body with no bytes left");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(phase_ff) && $stable(mss_ff))
      else $error("parser state moved without a beat");
`endif

endmodule

[design/tcpop_out_reg.sv]
`timescale 1ns / 1ps
module tcpop_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  tcpop_pkg::summary_type result_in,
   input  logic                   out_ready,
   output logic                   out_valid,
   output logic                   out_free,
   output tcpop_pkg::summary_type result_out
);

   logic                   valid_ff, valid_in;
   tcpop_pkg::summary_type result_ff;

   assign out_free = !valid_ff || out_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign result_out = result_ff;

endmodule

[design/tcp_option_parser.sv]
`timescale 1ns / 1ps
// TCP header option parser.
// req_ch: one beat per option byte (kind 0) and a closing beat (kind 1) that
//    ends the options area. Option bytes give no result; each closing beat
//    gives one summary beat on rsp_ch: mss, window_shift, sack_permitted and
//    malformed.
// csr_ch: writes min_mss, always ready; write only while the block is idle.
// Path: a beat lands in the input register and is parsed when taken from it;
//    for a closing beat, the parser's registered summary is then loaded into
//    the output register, which drives rsp_ch.
// Throughput: one beat per cycle unless a closing beat waits on rsp_ch, set by
//    the single byte-wise parse step between the input and output registers.
// Stall: while rsp_ch is held off, a closing beat waits in the input
//    register and req_ch drops ready once that register is full; option
//    bytes behind it are not taken until it leaves.
// Reset: min_mss returns to 536, the parser to its empty-area state and both
//    registers empty.
module tcp_option_parser (
   input  logic          clock,
   input  logic          reset,
   tcpop_req_if.sink     req_ch,
   tcpop_rsp_if.source   rsp_ch,
   tcpop_csr_if.sink     csr_ch
);

   logic [15:0]            min_mss_ff;
   logic                   req_load;
   logic                   consume;
   logic                   emit;
   logic                   beat_valid;
   logic                   out_free;
   logic                   out_valid;
   tcpop_pkg::beat_type    beat_in;
   tcpop_pkg::beat_type    beat;
   tcpop_pkg::summary_type result;
   tcpop_pkg::summary_type result_out;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_mss_ff <= tcpop_pkg::MIN_MSS_RESET;
      end else if (csr_ch.valid) begin
         min_mss_ff <= csr_ch.min_mss;
      end
   end

   // option bytes always drain; a closing beat waits for a free output
   assign consume      = beat_valid && (beat.kind == tcpop_pkg::KIND_BYTE || out_free);
   assign emit         = consume && beat.kind == tcpop_pkg::KIND_END;
   assign req_ch.ready = !beat_valid || consume;
   assign req_load     = req_ch.valid && req_ch.ready;

   assign beat_in.kind     = req_ch.kind;
   assign beat_in.opt_byte = req_ch.opt_byte;

   tcpop_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_load),
      .consume    (consume),
      .beat_in    (beat_in),
      .beat_valid (beat_valid),
      .beat_out   (beat)
   );

   tcpop_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .take    (consume),
      .beat    (beat),
      .min_mss (min_mss_ff),
      .result  (result)
   );

   tcpop_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .result_in  (result),
      .out_ready  (rsp_ch.ready),
      .out_valid  (out_valid),
      .out_free   (out_free),
      .result_out (result_out)
   );

   assign rsp_ch.valid          = out_valid;
   assign rsp_ch.mss            = result_out.mss;
   assign rsp_ch.window_shift   = result_out.window_shift;
   assign rsp_ch.sack_permitted = result_out.sack_permitted;
   assign rsp_ch.malformed      = result_out.malformed;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (emit) |-> (!out_valid || rsp_ch.ready))
      else $error("summary loaded over an untaken one");
   a_end_waits: assert property (@(posedge clock) disable iff (reset)
      (beat_valid && beat.kind == tcpop_pkg::KIND_END && !out_free) |-> !req_ch.ready)
      else $error("input taken while closing beat is blocked");
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> out_valid)
      else $error("summary lost after closing beat");
`endif

endmodule
